[hw/rtl/sts_pkg.sv]
// Shared types, widths and constant tables for the Taylor series sine block.
package sts_pkg;

  // Field widths of the transaction ports
  localparam int ANGLE_W = 31;
  localparam int TERMS_W = 4;
  localparam int OUT_W   = 32;
  localparam int OUT_FRAC = 24;

  // Defaults for the top level parameters
  localparam int DEF_MAX_TERMS       = 12;
  localparam int DEF_ANGLE_FRAC_BITS = 28;

  // Shared multiplier: 32x32 limbs, two-limb operands, accumulator wide enough
  // for a 48-bit by 46-bit product
  localparam int LIMB_W = 32;
  localparam int OP_W   = 2 * LIMB_W;
  localparam int ACC_W  = 96;

  // Running sum, signed; magnitude stays below 2^53
  localparam int SUM_W = 56;

  // Term divisor (2k)(2k+1) and its truncated reciprocal 2^RECIP_S / d
  localparam int K_MAX    = 16;
  localparam int K_IDX_W  = 4;
  localparam int DIV_W    = 11;
  localparam int RECIP_S  = 48;
  localparam int RECIP_W  = 46;

  localparam logic [DIV_W-1:0] DIV_TAB [K_MAX] = '{
    11'd6,   11'd20,  11'd42,  11'd72,  11'd110, 11'd156, 11'd210, 11'd272,
    11'd342, 11'd420, 11'd506, 11'd600, 11'd702, 11'd812, 11'd930, 11'd1056
  };

  localparam logic [RECIP_W-1:0] RECIP_TAB [K_MAX] = '{
    RECIP_W'((64'd1 << RECIP_S) / 64'd6),
    RECIP_W'((64'd1 << RECIP_S) / 64'd20),
    RECIP_W'((64'd1 << RECIP_S) / 64'd42),
    RECIP_W'((64'd1 << RECIP_S) / 64'd72),
    RECIP_W'((64'd1 << RECIP_S) / 64'd110),
    RECIP_W'((64'd1 << RECIP_S) / 64'd156),
    RECIP_W'((64'd1 << RECIP_S) / 64'd210),
    RECIP_W'((64'd1 << RECIP_S) / 64'd272),
    RECIP_W'((64'd1 << RECIP_S) / 64'd342),
    RECIP_W'((64'd1 << RECIP_S) / 64'd420),
    RECIP_W'((64'd1 << RECIP_S) / 64'd506),
    RECIP_W'((64'd1 << RECIP_S) / 64'd600),
    RECIP_W'((64'd1 << RECIP_S) / 64'd702),
    RECIP_W'((64'd1 << RECIP_S) / 64'd812),
    RECIP_W'((64'd1 << RECIP_S) / 64'd930),
    RECIP_W'((64'd1 << RECIP_S) / 64'd1056)
  };

  // One limb product request to the shared multiplier
  typedef struct packed {
    logic              issue;
    logic              clr;
    logic [1:0]        sh;
    logic [LIMB_W-1:0] a;
    logic [LIMB_W-1:0] b;
  } mul_cmd_t;

  // Status handed to the output formatter
  typedef struct packed {
    logic neg;
    logic ovf;
    logic ovf_neg;
    logic clamp;
  } fmt_flags_t;

endpackage

[hw/rtl/sts_mul.sv]
// Shared 32x32 limb multiplier with registered product and shifting accumulator.
module sts_mul
  import sts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  mul_cmd_t         cmd,
  output logic [ACC_W-1:0] acc
);

  logic [OP_W-1:0]  prod_r;
  logic [1:0]       prod_sh_r;
  logic             prod_v_r;
  logic             clr_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic [ACC_W-1:0] addend;

  // Register one limb product per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      clr_r    <= 1'b0;
    end else begin
      prod_v_r <= cmd.issue;
      clr_r    <= cmd.issue & cmd.clr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      prod_r    <= OP_W'(cmd.a) * OP_W'(cmd.b);
      prod_sh_r <= cmd.sh;
    end
  end

  // Align the registered product to its limb position
  always_comb begin
    addend = '0;
    if (prod_v_r) begin
      unique case (prod_sh_r)
        2'd0:    addend = ACC_W'(prod_r);
        2'd1:    addend = ACC_W'({prod_r, {LIMB_W{1'b0}}});
        2'd2:    addend = ACC_W'({prod_r, {OP_W{1'b0}}});
        default: addend = '0;
      endcase
    end
  end

  // Restart the sum with the first product of a multiply, else accumulate
  assign acc_nxt = (clr_r ? '0 : acc_r) + addend;

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

[hw/rtl/sts_fmt.sv]
// Conversion of the series sum to saturated signed Q8.24.
module sts_fmt
  import sts_pkg::*;
#(
  parameter int FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  fmt_flags_t       flags,
  input  logic [SUM_W-1:0] mag,
  output logic [OUT_W-1:0] value,
  output logic             clipped
);

  localparam int SHR = (FRAC_BITS >= OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam int SHL = (FRAC_BITS <  OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
  localparam logic [OP_W-1:0]  POS_MAX  = OP_W'(64'h7FFF_FFFF);
  localparam logic [OP_W-1:0]  NEG_MAX  = OP_W'(64'h8000_0000);
  localparam logic [SUM_W-1:0] MAG_LIM  = SUM_W'(1) << 40;

  logic [OP_W-1:0]  q;
  logic [OP_W-1:0]  q_sat;
  logic             sat;
  logic [OUT_W-1:0] lo;

  // Rescale the magnitude to 24 fraction bits, truncating, or clamping at 2^40 before a left shift
  always_comb begin
    if (FRAC_BITS >= OUT_FRAC) begin
      q = OP_W'(mag) >> SHR;
    end else if (mag > MAG_LIM) begin
      q = OP_W'(MAG_LIM);
    end else begin
      q = OP_W'(mag) << SHL;
    end
  end

  // Clip to the signed 32-bit range and restore the sign
  always_comb begin
    q_sat = q;
    sat   = 1'b0;
    if (!flags.neg && q > POS_MAX) begin
      q_sat = POS_MAX;
      sat   = 1'b1;
    end else if (flags.neg && q > NEG_MAX) begin
      q_sat = NEG_MAX;
      sat   = 1'b1;
    end
    lo = q_sat[OUT_W-1:0];
    if (flags.ovf) begin
      value   = flags.ovf_neg ? NEG_MAX[OUT_W-1:0] : POS_MAX[OUT_W-1:0];
      clipped = 1'b1;
    end else begin
      value   = flags.neg ? (~lo + OUT_W'(1)) : lo;
      clipped = sat | flags.clamp;
    end
  end

endmodule

[hw/rtl/sine_taylor_series.sv]
// Top level: sequencer for the Taylor series sine over one shared multiplier.
//
// A transaction is taken when start is high and busy is low; the block then
// stays busy while it sums n terms, n being the term count after clamping to
// MAX_TERMS, and shows the result with out_valid for exactly one cycle just
// after busy falls. A term overflow ends the series early.
// All arithmetic runs as two-limb products on a single 32x32 multiplier: x^2
// takes one multiply, and each term takes three (t*x^2, a reciprocal multiply
// for the divide by (2k)(2k+1), and a check multiply for the quotient),
// followed by a step that corrects the quotient and updates the sum.
// The result is not held: the receiver must take it in the strobe cycle.
module sine_taylor_series
  import sts_pkg::*;
#(
  parameter int MAX_TERMS       = DEF_MAX_TERMS,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [ANGLE_W-1:0]      in_angle,
  input  logic [TERMS_W-1:0]      in_terms,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_sine_value,
  output logic                    out_clipped
);

  localparam int N_W  = $clog2(MAX_TERMS + 1);
  localparam int X2_W = 2 * ANGLE_W - ANGLE_FRAC_BITS;
  localparam int U_W  = OP_W - ANGLE_FRAC_BITS;
  localparam int T_W  = (U_W > ANGLE_W) ? U_W : ANGLE_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_TM   = 3'd2;
  localparam logic [2:0] ST_RC   = 3'd3;
  localparam logic [2:0] ST_QD   = 3'd4;
  localparam logic [2:0] ST_FIX  = 3'd5;
  localparam logic [2:0] ST_MAG  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  // Multiply steps: four limb products, one drain, one capture
  localparam logic [2:0] STEP_LAST_ISSUE = 3'd3;
  localparam logic [2:0] STEP_DONE       = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [2:0]         step_r, step_nxt;
  logic               mul_state;
  logic               mul_done;

  logic [ANGLE_W-1:0] a_r;
  logic [N_W-1:0]     n_r;
  logic [N_W-1:0]     k_r;
  logic               clamp_r;
  logic [X2_W-1:0]    x2_r;
  logic [T_W-1:0]     t_r;
  logic [U_W-1:0]     u_r;
  logic [U_W-1:0]     q_r;
  logic               inc_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   mag_r;
  logic               neg_r;
  logic               ovf_r;
  logic               ovf_neg_r;

  logic               out_valid_r;
  logic [OUT_W-1:0]   out_value_r;
  logic               out_clipped_r;

  logic [K_IDX_W-1:0] k_idx;
  logic [DIV_W-1:0]   div_k;
  logic [RECIP_W-1:0] recip_k;
  logic               k_odd;
  logic               accept;
  logic               terms_big;
  logic               ovf_hit;

  logic [OP_W-1:0]    op_a, op_b;
  mul_cmd_t           mul_cmd;
  logic [ACC_W-1:0]   acc;
  logic [U_W-1:0]     rem;

  fmt_flags_t         flags;
  logic [OUT_W-1:0]   fmt_value;
  logic               fmt_clipped;

  assign accept    = start & ~busy;
  assign busy      = (state_r != ST_IDLE);
  assign terms_big = 32'(in_terms) > 32'(MAX_TERMS);

  assign k_idx   = K_IDX_W'(k_r - N_W'(1));
  assign div_k   = DIV_TAB[k_idx];
  assign recip_k = RECIP_TAB[k_idx];
  assign k_odd   = k_r[0];

  assign mul_state = (state_r == ST_SQ) || (state_r == ST_TM) ||
                     (state_r == ST_RC) || (state_r == ST_QD);
  assign mul_done  = mul_state && (step_r == STEP_DONE);

  // A product of 2^64 or more means the term no longer fits
  assign ovf_hit = (acc[ACC_W-1:OP_W] != '0);

  // Select the operands of the current multiply
  always_comb begin
    unique case (state_r)
      ST_SQ: begin
        op_a = OP_W'(a_r);
        op_b = OP_W'(a_r);
      end
      ST_TM: begin
        op_a = OP_W'(t_r);
        op_b = OP_W'(x2_r);
      end
      ST_RC: begin
        op_a = OP_W'(u_r);
        op_b = OP_W'(recip_k);
      end
      ST_QD: begin
        op_a = OP_W'(q_r);
        op_b = OP_W'(div_k);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Issue one limb pair per step
  always_comb begin
    mul_cmd.issue = mul_state && (step_r <= STEP_LAST_ISSUE);
    mul_cmd.clr   = (step_r == '0);
    mul_cmd.sh    = {1'b0, step_r[1]} + {1'b0, step_r[0]};
    mul_cmd.a     = step_r[1] ? op_a[OP_W-1:LIMB_W] : op_a[LIMB_W-1:0];
    mul_cmd.b     = step_r[0] ? op_b[OP_W-1:LIMB_W] : op_b[LIMB_W-1:0];
  end

  sts_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mul_cmd),
    .acc   (acc)
  );

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    if (mul_state) begin
      step_nxt = mul_done ? '0 : step_r + 3'd1;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SQ;
          step_nxt  = '0;
        end
      end
      ST_SQ: begin
        if (mul_done) begin
          state_nxt = (n_r == '0) ? ST_MAG : ST_TM;
        end
      end
      ST_TM: begin
        if (mul_done) begin
          state_nxt = ovf_hit ? ST_OUT : ST_RC;
        end
      end
      ST_RC: begin
        if (mul_done) begin
          state_nxt = ST_QD;
        end
      end
      ST_QD: begin
        if (mul_done) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        state_nxt = (k_r == n_r) ? ST_MAG : ST_TM;
      end
      ST_MAG: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= (state_r == ST_OUT);
    end
  end

  // Remainder of the quotient estimate; one below the truth at most
  assign rem = u_r - U_W'(acc);

  // Capture multiply results and update the series
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          a_r       <= in_angle;
          n_r       <= terms_big ? N_W'(MAX_TERMS) : N_W'(in_terms);
          clamp_r   <= terms_big;
          k_r       <= N_W'(1);
          t_r       <= T_W'(in_angle);
          sum_r     <= SUM_W'(in_angle);
          ovf_r     <= 1'b0;
          ovf_neg_r <= 1'b0;
        end
      end
      ST_SQ: begin
        if (mul_done) begin
          x2_r <= acc[ANGLE_FRAC_BITS +: X2_W];
        end
      end
      ST_TM: begin
        if (mul_done) begin
          u_r <= acc[ANGLE_FRAC_BITS +: U_W];
          if (ovf_hit) begin
            ovf_r     <= 1'b1;
            ovf_neg_r <= k_odd;
          end
        end
      end
      ST_RC: begin
        if (mul_done) begin
          q_r <= acc[RECIP_S +: U_W];
        end
      end
      ST_QD: begin
        if (mul_done) begin
          inc_r <= (rem >= U_W'(div_k));
        end
      end
      ST_FIX: begin
        // The quotient is below 2^36, so the term cap is never reached
        t_r   <= T_W'(q_r + U_W'(inc_r));
        sum_r <= k_odd ? sum_r - SUM_W'(q_r + U_W'(inc_r))
                       : sum_r + SUM_W'(q_r + U_W'(inc_r));
        k_r   <= k_r + N_W'(1);
      end
      ST_MAG: begin
        neg_r <= sum_r[SUM_W-1];
        mag_r <= sum_r[SUM_W-1] ? (~sum_r + SUM_W'(1)) : sum_r;
      end
      ST_OUT: begin
        out_value_r   <= fmt_value;
        out_clipped_r <= fmt_clipped;
      end
      default: begin
      end
    endcase
  end

  // Format the result; an overflowed series skips the magnitude step
  assign flags.neg     = neg_r & ~ovf_r;
  assign flags.ovf     = ovf_r;
  assign flags.ovf_neg = ovf_neg_r;
  assign flags.clamp   = clamp_r;

  sts_fmt #(
    .FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_fmt (
    .flags   (flags),
    .mag     (mag_r),
    .value   (fmt_value),
    .clipped (fmt_clipped)
  );

  assign out_valid      = out_valid_r;
  assign out_sine_value = $signed(out_value_r);
  assign out_clipped    = out_clipped_r;

endmodule
